@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the RTL of the reprojection residual block.
// Every macro samples on the rising edge of clock and is disabled while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/idrr_pkg.sv @@
// Package for the inverse depth reprojection residual block: types, constants
// and the fixed point helper functions. It depends on nothing else.
package idrr_pkg;

   localparam int PIXEL_FRAC_BITS = 16;
   localparam int FOCAL_PIXELS    = 2700;
   localparam logic [30:0] FOCAL_RESET = 31'(FOCAL_PIXELS << PIXEL_FRAC_BITS);

   localparam int ANG_FRAC  = 28;
   localparam int DIV_STEPS = 64;
   localparam int DIV_W     = 62;

   typedef logic signed [62:0] val_type;
   typedef logic [61:0]        mag_type;
   typedef logic signed [31:0] word_type;

   localparam val_type ONE_ANG = val_type'(64'sd1 <<< ANG_FRAC);
   localparam logic signed [63:0] MAG_LIM  = 64'sd1 <<< 62;
   localparam logic signed [63:0] MAG_NLIM = -(64'sd1 <<< 62);

   // Partial products of a 32-bit by 62-bit magnitude multiplication.
   typedef struct packed {
      logic [63:0] lo;
      logic [61:0] hi;
      logic        neg;
   } pp_type;

   typedef struct packed {
      val_type v;
      logic    ovf;
   } chk_type;

   function automatic mag_type mag_of(val_type v);
      val_type n;
      n = -v;
      return v[62] ? n[61:0] : v[61:0];
   endfunction

   function automatic logic [31:0] mag32(word_type a);
      word_type n;
      n = -a;
      return a[31] ? n : a;
   endfunction

   function automatic val_type wide(word_type a);
      return val_type'(a);
   endfunction

   function automatic pp_type mul_part(word_type a, val_type b);
      pp_type      p;
      mag_type     mb;
      logic [31:0] ma;
      mb    = mag_of(b);
      ma    = mag32(a);
      p.lo  = 64'(ma) * 64'(mb[31:0]);
      p.hi  = 62'(ma) * 62'(mb[61:32]);
      p.neg = a[31] ^ b[62];
      return p;
   endfunction

   // Product divided by 2^28 and truncated toward zero, flagged at 2^62.
   function automatic chk_type mul_fin(pp_type p);
      chk_type     c;
      logic [93:0] s;
      logic [65:0] r;
      val_type     m;
      s     = 94'(p.lo) + {p.hi, 32'b0};
      r     = s[93:28];
      m     = val_type'({1'b0, r[61:0]});
      c.ovf = |r[65:62];
      c.v   = p.neg ? -m : m;
      return c;
   endfunction

   function automatic chk_type add_chk(val_type a, val_type b);
      chk_type           c;
      logic signed [63:0] s;
      s     = 64'(a) + 64'(b);
      c.ovf = (s >= MAG_LIM) || (s <= MAG_NLIM);
      c.v   = s[62:0];
      return c;
   endfunction

   function automatic chk_type sub_chk(val_type a, val_type b);
      chk_type           c;
      logic signed [63:0] s;
      s     = 64'(a) - 64'(b);
      c.ovf = (s >= MAG_LIM) || (s <= MAG_NLIM);
      c.v   = s[62:0];
      return c;
   endfunction

endpackage

@@ hw/rtl/idrr_req_if.sv @@
// Observation channel of the reprojection residual block.
// Uses nothing but plain logic signals.
interface idrr_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] obs_x;
   logic signed [31:0] obs_y;
   logic signed [31:0] ref_x;
   logic signed [31:0] ref_y;
   logic signed [31:0] rot_x;
   logic signed [31:0] rot_y;
   logic signed [31:0] rot_z;
   logic signed [31:0] trans_x;
   logic signed [31:0] trans_y;
   logic signed [31:0] trans_z;
   logic signed [31:0] inv_depth;

   modport source (output valid, obs_x, obs_y, ref_x, ref_y, rot_x, rot_y, rot_z,
                   trans_x, trans_y, trans_z, inv_depth, input ready);
   modport sink   (input valid, obs_x, obs_y, ref_x, ref_y, rot_x, rot_y, rot_z,
                   trans_x, trans_y, trans_z, inv_depth, output ready);
endinterface

@@ hw/rtl/idrr_rsp_if.sv @@
// Residual channel of the reprojection residual block.
// Uses nothing but plain logic signals.
interface idrr_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] residual_x;
   logic signed [31:0] residual_y;
   logic               invalid;

   modport source (output valid, residual_x, residual_y, invalid, input ready);
   modport sink   (input valid, residual_x, residual_y, invalid, output ready);
endinterface

@@ hw/rtl/idrr_div.sv @@
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on idrr_pkg for its widths and step count.
module idrr_div (
   input  logic                        clock,
   input  logic                        en,
   input  logic [idrr_pkg::DIV_W-1:0]  dvsr,
   input  logic [idrr_pkg::DIV_W-1:0]  dvd_rem,
   input  logic [63:0]                 dvd_tail,
   output logic [63:0]                 quot
);

   localparam int S = idrr_pkg::DIV_STEPS;
   localparam int W = idrr_pkg::DIV_W;

   logic [W-1:0] rem_ff [0:S-1];
   logic [W-1:0] rem_in [0:S-1];
   logic [W-1:0] dv_ff  [0:S-1];
   logic [W-1:0] dv_in  [0:S-1];
   logic [63:0]  tq_ff  [0:S-1];
   logic [63:0]  tq_in  [0:S-1];

   // The tail bits leave at the top of tq while quotient bits enter at the bottom.
   always_comb begin
      logic [W:0]   r2;
      logic [W:0]   diff;
      logic [W-1:0] rp;
      logic [W-1:0] dp;
      logic [63:0]  tp;
      logic         ge;
      for (int s = 0; s < S; s++) begin
         if (s == 0) begin
            rp = dvd_rem;
            dp = dvsr;
            tp = dvd_tail;
         end else begin
            rp = rem_ff[s-1];
            dp = dv_ff[s-1];
            tp = tq_ff[s-1];
         end
         r2        = {rp, tp[63]};
         diff      = r2 - {1'b0, dp};
         ge        = r2 >= {1'b0, dp};
         rem_in[s] = ge ? diff[W-1:0] : r2[W-1:0];
         dv_in[s]  = dp;
         tq_in[s]  = {tp[62:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s < S; s++) begin
            rem_ff[s] <= rem_in[s];
            dv_ff[s]  <= dv_in[s];
            tq_ff[s]  <= tq_in[s];
         end
      end
   end

   assign quot = tq_ff[S-1];

endmodule

@@ hw/rtl/inverse_depth_reprojection_residual.sv @@
// Inverse depth reprojection residual, one observation per transaction.
// Two levels of 64-stage restoring dividers; throughput is one transaction per
// cycle while the result side does not stall, because every stage is pipelined.
// A stall at the result side freezes the whole pipeline in place.
// Reset clears all valid bits and sets the focal length to 2700.0 pixels.
`include "assert_macros.svh"

module inverse_depth_reprojection_residual (
   input  logic              clock,
   input  logic              reset,
   idrr_req_if.sink          req_ch,
   idrr_rsp_if.source        rsp_ch,
   input  logic              csr_wr_en,
   input  logic [30:0]       csr_wr_data
);

   localparam int S    = idrr_pkg::DIV_STEPS;
   localparam int NSTG = 2 * S + 12;
   // Stage positions in the valid chain.
   localparam int ST_PR = S + 10;

   typedef idrr_pkg::val_type  val_type;
   typedef idrr_pkg::word_type word_type;
   typedef idrr_pkg::pp_type   pp_type;
   typedef idrr_pkg::chk_type  chk_type;

   // Values that ride alongside the first divider.
   typedef struct packed {
      word_type    px, py, thx, thy, thz, tx, ty, tz, w;
      logic [30:0] f;
      logic        rxpos, rypos, bad;
   } side1_type;

   typedef struct packed {
      val_type     xj, yj;
      word_type    px, py, thx, thy, thz, tx, ty, tz, w;
      logic [30:0] f;
      logic        bad;
   } sa_type;

   typedef struct packed {
      pp_type      p1, p2, p3, p4, q1, q2, q3, q4, q5;
      val_type     xj, yj, thx, thy;
      word_type    px, py, w;
      logic [30:0] f;
      logic        bad;
   } m1a_type;

   typedef struct packed {
      val_type     p1, p2, p3, p4, q1, q2, q3, q4, q5;
      val_type     xj, yj, thx, thy;
      word_type    px, py, w;
      logic [30:0] f;
      logic        bad;
   } m1b_type;

   typedef struct packed {
      val_type     c1, ax1, ay1, fx, fy, p2, p4, thy, tzw;
      word_type    px, py, w;
      logic [30:0] f;
      logic        bad;
   } a1a_type;

   typedef struct packed {
      val_type     c, ax, ay, fx, fy, tzw;
      word_type    px, py, w;
      logic [30:0] f;
      logic        bad;
   } a1b_type;

   typedef struct packed {
      pp_type  pxc, axf, pyc, ayf, fxw, fyw;
      val_type den;
      logic    bad;
   } m2a_type;

   typedef struct packed {
      val_type pxc, axf, pyc, ayf, fxw, fyw, den;
      logic    bad;
   } m2b_type;

   typedef struct packed {
      val_type ex, ey, fxw, fyw, den;
      logic    bad;
   } a2a_type;

   typedef struct packed {
      val_type nx, ny, den;
      logic    bad;
   } a2b_type;

   // Flags that ride alongside the second divider.
   typedef struct packed {
      logic bad, denz, nxneg, nyneg, negx, negy, bigx, bigy;
   } side2_type;

   typedef struct packed {
      logic [idrr_pkg::DIV_W-1:0] md, remx, remy;
      logic [63:0]                tailx, taily;
      side2_type                  sd;
   } pr_type;

   typedef struct packed {
      word_type rx, ry;
      logic     inv;
   } out_type;

   typedef struct packed {
      word_type r;
      logic     inv;
   } sat_type;

   // Clamp a quotient magnitude to the signed 32-bit range of its sign.
   function automatic sat_type saturate(logic [63:0] q, logic neg, logic big);
      sat_type     s;
      logic [63:0] lim;
      word_type    qn;
      lim = neg ? 64'h0000_0000_8000_0000 : 64'h0000_0000_7FFF_FFFF;
      qn  = -word_type'(q[31:0]);
      if (big || q > lim) begin
         s.r   = neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
         s.inv = 1'b1;
      end else begin
         s.r   = neg ? qn : word_type'(q[31:0]);
         s.inv = 1'b0;
      end
      return s;
   endfunction

   logic            en;
   logic [30:0]     focal_ff;
   logic [NSTG-1:0] vld_ff;

   side1_type s0_ff, s0_in;
   side1_type sd1_ff [0:S-1];
   sa_type    sa_ff,  sa_in;
   m1a_type   m1a_ff, m1a_in;
   m1b_type   m1b_ff, m1b_in;
   a1a_type   a1a_ff, a1a_in;
   a1b_type   a1b_ff, a1b_in;
   m2a_type   m2a_ff, m2a_in;
   m2b_type   m2b_ff, m2b_in;
   a2a_type   a2a_ff, a2a_in;
   a2b_type   a2b_ff, a2b_in;
   pr_type    pr_ff,  pr_in;
   side2_type sd2_ff [0:S-1];
   out_type   out_ff, out_in;

   logic [63:0] rx_tail, ry_tail;
   logic [63:0] qx1, qy1, qx2, qy2;

   // The whole pipeline moves together whenever the output register can take
   // a new transaction, so valid bits and payload never part ways.
   assign en           = !vld_ff[NSTG-1] || rsp_ch.ready;
   assign req_ch.ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         focal_ff <= idrr_pkg::FOCAL_RESET;
      end else if (csr_wr_en) begin
         focal_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NSTG-2:0], req_ch.valid};
      end
   end

   // Input stage: capture the observation together with the focal length.
   always_comb begin
      s0_in.px    = req_ch.obs_x;
      s0_in.py    = req_ch.obs_y;
      s0_in.thx   = req_ch.rot_x;
      s0_in.thy   = req_ch.rot_y;
      s0_in.thz   = req_ch.rot_z;
      s0_in.tx    = req_ch.trans_x;
      s0_in.ty    = req_ch.trans_y;
      s0_in.tz    = req_ch.trans_z;
      s0_in.w     = req_ch.inv_depth;
      s0_in.f     = focal_ff;
      s0_in.rxpos = req_ch.ref_x > 0;
      s0_in.rypos = req_ch.ref_y > 0;
      s0_in.bad   = focal_ff == '0;
   end

   logic [31:0] s0_rx_mag_ff, s0_ry_mag_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s0_ff        <= s0_in;
         s0_rx_mag_ff <= idrr_pkg::mag32(req_ch.ref_x);
         s0_ry_mag_ff <= idrr_pkg::mag32(req_ch.ref_y);
      end
   end

   // The reference pixel divided by the focal length, scaled by 2^28.
   assign rx_tail = {4'b0, s0_rx_mag_ff, 28'b0};
   assign ry_tail = {4'b0, s0_ry_mag_ff, 28'b0};

   idrr_div u_div_xj (
      .clock    (clock),
      .en       (en),
      .dvsr     ({31'b0, s0_ff.f}),
      .dvd_rem  ('0),
      .dvd_tail (rx_tail),
      .quot     (qx1)
   );

   idrr_div u_div_yj (
      .clock    (clock),
      .en       (en),
      .dvsr     ({31'b0, s0_ff.f}),
      .dvd_rem  ('0),
      .dvd_tail (ry_tail),
      .quot     (qy1)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         sd1_ff[0] <= s0_ff;
         for (int s = 1; s < S; s++) begin
            sd1_ff[s] <= sd1_ff[s-1];
         end
      end
   end

   // Normalized image coordinates carry the opposite sign of the pixel.
   always_comb begin
      val_type mx, my;
      mx        = val_type'({1'b0, qx1[61:0]});
      my        = val_type'({1'b0, qy1[61:0]});
      sa_in.xj  = sd1_ff[S-1].rxpos ? -mx : mx;
      sa_in.yj  = sd1_ff[S-1].rypos ? -my : my;
      sa_in.px  = sd1_ff[S-1].px;
      sa_in.py  = sd1_ff[S-1].py;
      sa_in.thx = sd1_ff[S-1].thx;
      sa_in.thy = sd1_ff[S-1].thy;
      sa_in.thz = sd1_ff[S-1].thz;
      sa_in.tx  = sd1_ff[S-1].tx;
      sa_in.ty  = sd1_ff[S-1].ty;
      sa_in.tz  = sd1_ff[S-1].tz;
      sa_in.w   = sd1_ff[S-1].w;
      sa_in.f   = sd1_ff[S-1].f;
      sa_in.bad = sd1_ff[S-1].bad;
   end

   // First product level: rotation terms and the translation terms that need
   // only the raw inputs. Each product is split into two partial products.
   always_comb begin
      word_type fw;
      val_type  fv;
      fw         = word_type'({1'b0, sa_ff.f});
      fv         = val_type'({32'b0, sa_ff.f});
      m1a_in.p1  = idrr_pkg::mul_part(sa_ff.thy, sa_ff.xj);
      m1a_in.p2  = idrr_pkg::mul_part(sa_ff.thx, sa_ff.yj);
      m1a_in.p3  = idrr_pkg::mul_part(sa_ff.thz, sa_ff.yj);
      m1a_in.p4  = idrr_pkg::mul_part(sa_ff.thz, sa_ff.xj);
      m1a_in.q1  = idrr_pkg::mul_part(sa_ff.px, idrr_pkg::wide(sa_ff.tz));
      m1a_in.q2  = idrr_pkg::mul_part(sa_ff.tx, fv);
      m1a_in.q3  = idrr_pkg::mul_part(sa_ff.py, idrr_pkg::wide(sa_ff.tz));
      m1a_in.q4  = idrr_pkg::mul_part(sa_ff.ty, fv);
      m1a_in.q5  = idrr_pkg::mul_part(sa_ff.tz, idrr_pkg::wide(sa_ff.w));
      m1a_in.xj  = sa_ff.xj;
      m1a_in.yj  = sa_ff.yj;
      m1a_in.thx = idrr_pkg::wide(sa_ff.thx);
      m1a_in.thy = idrr_pkg::wide(sa_ff.thy);
      m1a_in.px  = sa_ff.px;
      m1a_in.py  = sa_ff.py;
      m1a_in.w   = sa_ff.w;
      m1a_in.f   = sa_ff.f;
      m1a_in.bad = sa_ff.bad;
      if (fw[31]) begin
         m1a_in.bad = 1'b1;
      end
   end

   always_comb begin
      chk_type r1, r2, r3, r4, r5, r6, r7, r8, r9;
      r1 = idrr_pkg::mul_fin(m1a_ff.p1);
      r2 = idrr_pkg::mul_fin(m1a_ff.p2);
      r3 = idrr_pkg::mul_fin(m1a_ff.p3);
      r4 = idrr_pkg::mul_fin(m1a_ff.p4);
      r5 = idrr_pkg::mul_fin(m1a_ff.q1);
      r6 = idrr_pkg::mul_fin(m1a_ff.q2);
      r7 = idrr_pkg::mul_fin(m1a_ff.q3);
      r8 = idrr_pkg::mul_fin(m1a_ff.q4);
      r9 = idrr_pkg::mul_fin(m1a_ff.q5);
      m1b_in.p1  = r1.v;
      m1b_in.p2  = r2.v;
      m1b_in.p3  = r3.v;
      m1b_in.p4  = r4.v;
      m1b_in.q1  = r5.v;
      m1b_in.q2  = r6.v;
      m1b_in.q3  = r7.v;
      m1b_in.q4  = r8.v;
      m1b_in.q5  = r9.v;
      m1b_in.xj  = m1a_ff.xj;
      m1b_in.yj  = m1a_ff.yj;
      m1b_in.thx = m1a_ff.thx;
      m1b_in.thy = m1a_ff.thy;
      m1b_in.px  = m1a_ff.px;
      m1b_in.py  = m1a_ff.py;
      m1b_in.w   = m1a_ff.w;
      m1b_in.f   = m1a_ff.f;
      m1b_in.bad = m1a_ff.bad | r1.ovf | r2.ovf | r3.ovf | r4.ovf | r5.ovf
                   | r6.ovf | r7.ovf | r8.ovf | r9.ovf;
   end

   // First half of the small-angle sums.
   always_comb begin
      chk_type c1, ax1, ay1, fx, fy;
      c1  = idrr_pkg::sub_chk(idrr_pkg::ONE_ANG, m1b_ff.p1);
      ax1 = idrr_pkg::sub_chk(m1b_ff.xj, m1b_ff.p3);
      ay1 = idrr_pkg::sub_chk(m1b_ff.yj, m1b_ff.thx);
      fx  = idrr_pkg::add_chk(m1b_ff.q1, m1b_ff.q2);
      fy  = idrr_pkg::add_chk(m1b_ff.q3, m1b_ff.q4);
      a1a_in.c1  = c1.v;
      a1a_in.ax1 = ax1.v;
      a1a_in.ay1 = ay1.v;
      a1a_in.fx  = fx.v;
      a1a_in.fy  = fy.v;
      a1a_in.p2  = m1b_ff.p2;
      a1a_in.p4  = m1b_ff.p4;
      a1a_in.thy = m1b_ff.thy;
      a1a_in.tzw = m1b_ff.q5;
      a1a_in.px  = m1b_ff.px;
      a1a_in.py  = m1b_ff.py;
      a1a_in.w   = m1b_ff.w;
      a1a_in.f   = m1b_ff.f;
      a1a_in.bad = m1b_ff.bad | c1.ovf | ax1.ovf | ay1.ovf | fx.ovf | fy.ovf;
   end

   always_comb begin
      chk_type c, ax, ay;
      c  = idrr_pkg::add_chk(a1a_ff.c1, a1a_ff.p2);
      ax = idrr_pkg::add_chk(a1a_ff.ax1, a1a_ff.thy);
      ay = idrr_pkg::add_chk(a1a_ff.ay1, a1a_ff.p4);
      a1b_in.c   = c.v;
      a1b_in.ax  = ax.v;
      a1b_in.ay  = ay.v;
      a1b_in.fx  = a1a_ff.fx;
      a1b_in.fy  = a1a_ff.fy;
      a1b_in.tzw = a1a_ff.tzw;
      a1b_in.px  = a1a_ff.px;
      a1b_in.py  = a1a_ff.py;
      a1b_in.w   = a1a_ff.w;
      a1b_in.f   = a1a_ff.f;
      a1b_in.bad = a1a_ff.bad | c.ovf | ax.ovf | ay.ovf;
   end

   // Second product level; the denominator add runs beside the multipliers.
   always_comb begin
      word_type fw;
      chk_type  den;
      fw          = word_type'({1'b0, a1b_ff.f});
      den         = idrr_pkg::add_chk(a1b_ff.c, a1b_ff.tzw);
      m2a_in.pxc  = idrr_pkg::mul_part(a1b_ff.px, a1b_ff.c);
      m2a_in.axf  = idrr_pkg::mul_part(fw, a1b_ff.ax);
      m2a_in.pyc  = idrr_pkg::mul_part(a1b_ff.py, a1b_ff.c);
      m2a_in.ayf  = idrr_pkg::mul_part(fw, a1b_ff.ay);
      m2a_in.fxw  = idrr_pkg::mul_part(a1b_ff.w, a1b_ff.fx);
      m2a_in.fyw  = idrr_pkg::mul_part(a1b_ff.w, a1b_ff.fy);
      m2a_in.den  = den.v;
      m2a_in.bad  = a1b_ff.bad | den.ovf;
   end

   always_comb begin
      chk_type r1, r2, r3, r4, r5, r6;
      r1 = idrr_pkg::mul_fin(m2a_ff.pxc);
      r2 = idrr_pkg::mul_fin(m2a_ff.axf);
      r3 = idrr_pkg::mul_fin(m2a_ff.pyc);
      r4 = idrr_pkg::mul_fin(m2a_ff.ayf);
      r5 = idrr_pkg::mul_fin(m2a_ff.fxw);
      r6 = idrr_pkg::mul_fin(m2a_ff.fyw);
      m2b_in.pxc = r1.v;
      m2b_in.axf = r2.v;
      m2b_in.pyc = r3.v;
      m2b_in.ayf = r4.v;
      m2b_in.fxw = r5.v;
      m2b_in.fyw = r6.v;
      m2b_in.den = m2a_ff.den;
      m2b_in.bad = m2a_ff.bad | r1.ovf | r2.ovf | r3.ovf | r4.ovf | r5.ovf | r6.ovf;
   end

   always_comb begin
      chk_type ex, ey;
      ex = idrr_pkg::add_chk(m2b_ff.pxc, m2b_ff.axf);
      ey = idrr_pkg::add_chk(m2b_ff.pyc, m2b_ff.ayf);
      a2a_in.ex  = ex.v;
      a2a_in.ey  = ey.v;
      a2a_in.fxw = m2b_ff.fxw;
      a2a_in.fyw = m2b_ff.fyw;
      a2a_in.den = m2b_ff.den;
      a2a_in.bad = m2b_ff.bad | ex.ovf | ey.ovf;
   end

   always_comb begin
      chk_type nx, ny;
      nx = idrr_pkg::add_chk(a2a_ff.ex, a2a_ff.fxw);
      ny = idrr_pkg::add_chk(a2a_ff.ey, a2a_ff.fyw);
      a2b_in.nx  = nx.v;
      a2b_in.ny  = ny.v;
      a2b_in.den = a2a_ff.den;
      a2b_in.bad = a2a_ff.bad | nx.ovf | ny.ovf;
   end

   // Prepare the final division. The numerator scaled by 2^28 is 90 bits wide;
   // its top 26 bits seed the remainder, and when they already reach the
   // divisor the quotient is far out of range.
   always_comb begin
      idrr_pkg::mag_type mnx, mny, md;
      mnx = idrr_pkg::mag_of(a2b_ff.nx);
      mny = idrr_pkg::mag_of(a2b_ff.ny);
      md  = idrr_pkg::mag_of(a2b_ff.den);
      pr_in.md       = md;
      pr_in.remx     = {36'b0, mnx[61:36]};
      pr_in.remy     = {36'b0, mny[61:36]};
      pr_in.tailx    = {mnx[35:0], 28'b0};
      pr_in.taily    = {mny[35:0], 28'b0};
      pr_in.sd.bad   = a2b_ff.bad;
      pr_in.sd.denz  = a2b_ff.den == '0;
      pr_in.sd.nxneg = a2b_ff.nx[62];
      pr_in.sd.nyneg = a2b_ff.ny[62];
      pr_in.sd.negx  = a2b_ff.nx[62] ^ a2b_ff.den[62];
      pr_in.sd.negy  = a2b_ff.ny[62] ^ a2b_ff.den[62];
      pr_in.sd.bigx  = {36'b0, mnx[61:36]} >= md;
      pr_in.sd.bigy  = {36'b0, mny[61:36]} >= md;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sa_ff  <= sa_in;
         m1a_ff <= m1a_in;
         m1b_ff <= m1b_in;
         a1a_ff <= a1a_in;
         a1b_ff <= a1b_in;
         m2a_ff <= m2a_in;
         m2b_ff <= m2b_in;
         a2a_ff <= a2a_in;
         a2b_ff <= a2b_in;
         pr_ff  <= pr_in;
      end
   end

   idrr_div u_div_rx (
      .clock    (clock),
      .en       (en),
      .dvsr     (pr_ff.md),
      .dvd_rem  (pr_ff.remx),
      .dvd_tail (pr_ff.tailx),
      .quot     (qx2)
   );

   idrr_div u_div_ry (
      .clock    (clock),
      .en       (en),
      .dvsr     (pr_ff.md),
      .dvd_rem  (pr_ff.remy),
      .dvd_tail (pr_ff.taily),
      .quot     (qy2)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         sd2_ff[0] <= pr_ff.sd;
         for (int s = 1; s < S; s++) begin
            sd2_ff[s] <= sd2_ff[s-1];
         end
      end
   end

   // Output stage. A zero focal length or any overflow gives the positive
   // limit on both residuals; a zero denominator saturates by the numerator's
   // sign; otherwise each quotient is clamped to the signed 32-bit range.
   always_comb begin
      side2_type sd;
      sat_type   sx, sy;
      sd = sd2_ff[S-1];
      sx = saturate(qx2, sd.negx, sd.bigx);
      sy = saturate(qy2, sd.negy, sd.bigy);
      if (sd.bad) begin
         out_in.rx  = 32'sh7FFF_FFFF;
         out_in.ry  = 32'sh7FFF_FFFF;
         out_in.inv = 1'b1;
      end else if (sd.denz) begin
         out_in.rx  = sd.nxneg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
         out_in.ry  = sd.nyneg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
         out_in.inv = 1'b1;
      end else begin
         out_in.rx  = sx.r;
         out_in.ry  = sy.r;
         out_in.inv = sx.inv | sy.inv;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff <= out_in;
      end
   end

   assign rsp_ch.valid      = vld_ff[NSTG-1];
   assign rsp_ch.residual_x = out_ff.rx;
   assign rsp_ch.residual_y = out_ff.ry;
   assign rsp_ch.invalid    = out_ff.inv;

   // A waiting result must hold off new observations.
   `ASSERT_IMPLY(a_stall_blocks_intake, rsp_ch.valid && !rsp_ch.ready, !req_ch.ready, "observation taken while result stalled")
   // While stalled, no transaction moves or vanishes anywhere in the pipeline.
   `ASSERT_NEXT(a_stall_freezes_pipe, !en, vld_ff == $past(vld_ff), "pipeline moved during a stall")
   // A transaction entering the final division must leave the prepare stage's
   // slot and land in the divider on the same advance.
   `ASSERT_NEXT(a_prep_advances, en && vld_ff[ST_PR], vld_ff[ST_PR+1], "transaction lost after division setup")

endmodule
